// ===== src/speck_pkg.sv =====
package speck_pkg;

    localparam int WORD_W     = 64;
    localparam int ROT_X      = 8;
    localparam int ROT_Y      = 3;
    localparam int ROUNDS_DEF = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_OTHER = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word x;
        t_word y;
    } t_word_pair;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word rk;
        t_word kl;
    } t_round_data;

    function automatic t_word_pair speck_round(input t_word x, input t_word y, input t_word k);
        t_word_pair r;
        t_word      xr;
        t_word      yl;
        xr   = (x >> ROT_X) | (x << (WORD_W - ROT_X));
        r.x  = (xr + y) ^ k;
        yl   = (y << ROT_Y) | (y >> (WORD_W - ROT_Y));
        r.y  = yl ^ r.x;
        return r;
    endfunction

endpackage

// ===== src/speck_round_stage.sv =====
module speck_round_stage #(
    parameter int unsigned ROUND_IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  speck_pkg::t_round_data  i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output speck_pkg::t_round_data  o_data
);
    import speck_pkg::*;

    logic        r_valid;
    t_round_data r_data;
    t_round_data n_data;
    t_word_pair  w_dat;
    t_word_pair  w_key;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        w_dat     = speck_round(i_data.x, i_data.y, i_data.rk);
        w_key     = speck_round(i_data.kl, i_data.rk, WORD_W'(ROUND_IDX));
        n_data.x  = w_dat.x;
        n_data.y  = w_dat.y;
        n_data.kl = w_key.x;
        n_data.rk = w_key.y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_data)))
        else $error("stalled stage lost or changed its transaction");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_ready)
        else $error("empty stage refused a transaction");
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_valid)
        else $error("accepted transaction not captured");
`endif

endmodule

// ===== src/speck_block_encrypt.sv =====
// Speck128/128 encryption, one round per pipeline stage.
// Each accepted block is registered in every round stage in turn before m_axis_tvalid.
// Throughput: one block per cycle unless the output stalls; each stage holds one
// transaction; a bubble anywhere in the chain is filled while the output is stalled.
// Reset (synchronous, active low) clears all stage valid bits and both key registers.
module speck_block_encrypt #(
    parameter int unsigned ROUNDS = speck_pkg::ROUNDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [speck_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [speck_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*speck_pkg::WORD_W-1:0]    s_axis_tdata,   // {plain_y, plain_x}
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*speck_pkg::WORD_W-1:0]    m_axis_tdata    // {cipher_y, cipher_x}
);
    import speck_pkg::*;

    t_word       r_key_round;
    t_word       r_key_other;
    logic        w_valid [0:ROUNDS];
    logic        w_ready [0:ROUNDS];
    t_round_data w_data  [0:ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_round <= '0;
            r_key_other <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_ROUND: r_key_round <= i_cfg_data;
                CFG_KEY_OTHER: r_key_other <= i_cfg_data;
            endcase
        end
    end

    assign w_valid[0]     = s_axis_tvalid;
    assign s_axis_tready  = w_ready[0];
    assign w_data[0].x    = s_axis_tdata[WORD_W-1:0];
    assign w_data[0].y    = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign w_data[0].rk   = r_key_round;
    assign w_data[0].kl   = r_key_other;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        speck_round_stage #(
            .ROUND_IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign m_axis_tvalid = w_valid[ROUNDS];
    assign w_ready[ROUNDS] = m_axis_tready;
    assign m_axis_tdata  = {w_data[ROUNDS].y, w_data[ROUNDS].x};

`ifndef NO_ASSERTIONS
    a_ready_follows_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");
    a_first_stage_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[1] |-> s_axis_tready)
        else $error("empty first stage refused input");
`endif

endmodule
